// File: src/lpg_pkg.sv
// Shared types and constants for the LED pixel gamma converter.
// No dependencies; imported by lpg_lane and led_pixel_gamma_convert.
package lpg_pkg;

    // Number of pixel lanes that are converted; lanes at or above this count output zero.
    localparam int LANE_COUNT = 2;
    // Pixel lanes carried by one transaction (upper row, lower row).
    localparam int IN_LANES   = 2;

    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int FMT_W   = 2;
    localparam int RGB_W   = 3 * CHAN_W;

    // Source pixel layouts selected by the format register.
    localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB888 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_NV12   = 2'd2;
    localparam logic [FMT_W-1:0] FMT_RESET  = FMT_NV12;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } lpg_rgb_t;

    // Pipeline load enables handed from the top level to every lane.
    typedef struct packed {
        logic load_conv;
        logic load_out;
    } lpg_ctrl_t;

endpackage

// File: src/lpg_lane.sv
// One pixel lane: color decode and clamp in the first stage, square-law gamma in the second.
// Depends on lpg_pkg.
module lpg_lane
    import lpg_pkg::*;
(
    input  logic              aclk,
    input  lpg_ctrl_t         ctrl,
    input  logic [FMT_W-1:0]  src_fmt,
    input  logic [PIX_W-1:0]  pixel,
    output lpg_rgb_t          rgb
);

    localparam int SUM_W = 19;

    localparam logic signed [SUM_W-1:0] COEF_RV = 19'sd359;
    localparam logic signed [SUM_W-1:0] COEF_GU = 19'sd88;
    localparam logic signed [SUM_W-1:0] COEF_GV = 19'sd183;
    localparam logic signed [SUM_W-1:0] COEF_BU = 19'sd453;
    localparam logic signed [SUM_W-1:0] SUM_TOP = 19'sd65536;

    function automatic logic [CHAN_W-1:0] clamp_q8(input logic signed [SUM_W-1:0] acc);
        logic [CHAN_W-1:0] res;
        if (acc < 0) begin
            res = '0;
        end else if (acc >= SUM_TOP) begin
            res = '1;
        end else begin
            res = acc[15:8];
        end
        return res;
    endfunction

    logic signed [9:0]       u_s;
    logic signed [9:0]       v_s;
    logic signed [SUM_W-1:0] u_w;
    logic signed [SUM_W-1:0] v_w;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;

    lpg_rgb_t chan_next;
    lpg_rgb_t chan_reg;
    lpg_rgb_t rgb_next;
    lpg_rgb_t rgb_reg;

    logic [2*CHAN_W-1:0] sq_r;
    logic [2*CHAN_W-1:0] sq_g;
    logic [2*CHAN_W-1:0] sq_b;

    always_comb begin
        u_s   = $signed({2'b00, pixel[15:8]}) - 10'sd128;
        v_s   = $signed({2'b00, pixel[23:16]}) - 10'sd128;
        u_w   = {{(SUM_W-10){u_s[9]}}, u_s};
        v_w   = {{(SUM_W-10){v_s[9]}}, v_s};
        base  = $signed({3'b000, pixel[7:0], 8'h00});
        sum_r = base + COEF_RV * v_w;
        sum_g = base - COEF_GU * u_w - COEF_GV * v_w;
        sum_b = base + COEF_BU * u_w;
    end

    // RGB565 channels are scaled up to 8 bits so that the shared c*c >> 8 step
    // yields r5*r5 >> 2 and g6*g6 >> 4.
    always_comb begin
        case (src_fmt)
            FMT_RGB565: begin
                chan_next.red   = {pixel[15:11], 3'b000};
                chan_next.green = {pixel[10:5], 2'b00};
                chan_next.blue  = {pixel[4:0], 3'b000};
            end
            FMT_RGB888: begin
                chan_next.red   = pixel[7:0];
                chan_next.green = pixel[15:8];
                chan_next.blue  = pixel[23:16];
            end
            FMT_NV12: begin
                chan_next.red   = clamp_q8(sum_r);
                chan_next.green = clamp_q8(sum_g);
                chan_next.blue  = clamp_q8(sum_b);
            end
            default: begin
                chan_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_conv) begin
            chan_reg <= chan_next;
        end
    end

    always_comb begin
        sq_r           = chan_reg.red * chan_reg.red;
        sq_g           = chan_reg.green * chan_reg.green;
        sq_b           = chan_reg.blue * chan_reg.blue;
        rgb_next.red   = sq_r[15:8];
        rgb_next.green = sq_g[15:8];
        rgb_next.blue  = sq_b[15:8];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

// File: src/led_pixel_gamma_convert.sv
// Top level of the LED pixel gamma converter: handshake, format register, lanes, merge.
// Depends on lpg_pkg and lpg_lane.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid / s_tready  s_tdata[47:0]: upper_pixel, lower_pixel
//   m_       out        m_tvalid / m_tready  m_tdata[47:0]: six 8-bit gamma channels
//   cfg_     in         cfg_valid/cfg_ready  cfg_data[1:0]: source pixel layout
//
// An accepted pixel pair goes through color decode and clamp into the decode register,
// then the squaring multipliers feeding the output register that drives m_tvalid. One
// pair is accepted per cycle while m_tready stays high. A stall on m_tready holds both
// stages; s_tready drops only when both are full. aresetn clears the valids and sets NV12.
module led_pixel_gamma_convert
    import lpg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // From bit 0: upper_pixel[23:0], lower_pixel[23:0].
    input  logic [IN_LANES*PIX_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // From bit 0: upper_red, upper_green, upper_blue, lower_red, lower_green, lower_blue.
    output logic [IN_LANES*RGB_W-1:0] m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [FMT_W-1:0]        cfg_data
);

    logic [FMT_W-1:0] fmt_reg;
    logic             conv_valid_reg;
    logic             conv_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             s_fire;
    lpg_ctrl_t        ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            fmt_reg <= cfg_data;
        end
    end

    always_comb begin
        ctrl.load_out   = !out_valid_reg || m_tready;
        ctrl.load_conv  = !conv_valid_reg || ctrl.load_out;
        s_tready        = ctrl.load_conv;
        s_fire          = s_tvalid && s_tready;
        conv_valid_next = ctrl.load_conv ? s_fire : conv_valid_reg;
        out_valid_next  = ctrl.load_out ? conv_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            conv_valid_reg <= conv_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Merge: each lane's output register lands in its own slice of the result word.
    for (genvar i = 0; i < IN_LANES; i++) begin : g_lane
        if (i < LANE_COUNT) begin : g_active
            lpg_rgb_t lane_rgb;

            lpg_lane u_lane (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .src_fmt (fmt_reg),
                .pixel   (s_tdata[i*PIX_W +: PIX_W]),
                .rgb     (lane_rgb)
            );

            assign m_tdata[i*RGB_W +: RGB_W] = {lane_rgb.blue, lane_rgb.green, lane_rgb.red};
        end else begin : g_off
            assign m_tdata[i*RGB_W +: RGB_W] = '0;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    // An empty decode stage must always be able to take a transaction.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !conv_valid_reg |-> s_tready)
        else $error("s_tready low with empty decode stage");

    // An accepted transaction occupies the decode stage in the next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> conv_valid_reg)
        else $error("accepted transaction lost from decode stage");

    // With the output stalled, a pending decode result is held, not dropped.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (conv_valid_reg && out_valid_reg && !m_tready) |=> (conv_valid_reg && out_valid_reg))
        else $error("pipeline dropped a transaction during a stall");

    // A transaction in the decode stage reaches the output register when it is free.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (conv_valid_reg && ctrl.load_out) |=> out_valid_reg)
        else $error("decode result did not advance to the output");
`endif

endmodule
